### rtl/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types, opcodes and constants of the tiny cpu execute unit.
// ----------------------------------------------------------------------------
package tce_pkg;

  // storage sizes and field widths
  localparam int unsigned RegCount = 16;
  localparam int unsigned MemDepth = 256;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PcW      = 16;
  localparam int unsigned RegIdxW  = 4;
  localparam int unsigned MemAddrW = 8;
  localparam int unsigned CostW    = 5;
  localparam int unsigned OpndW    = 16;

  // opcodes; codes past move are not implemented
  typedef enum logic [3:0] {
    OP_LOAD = 4'd0,
    OP_STORE = 4'd1,
    OP_STI = 4'd2,
    OP_IMM = 4'd3,
    OP_ADD = 4'd4,
    OP_SUB = 4'd5,
    OP_JZ = 4'd6,
    OP_MUL = 4'd7,
    OP_MOVE = 4'd8
  } tce_op_e;

  // input transaction
  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         first_reg;
    logic signed [15:0] operand;
  } tce_in_t;

  // result transaction
  typedef struct packed {
    logic [15:0]        next_pc;
    logic [4:0]         cycle_cost;
    logic               invalid_op;
    logic               reg_written;
    logic [3:0]         write_reg_index;
    logic signed [31:0] write_reg_value;
    logic               mem_written;
    logic [7:0]         write_mem_address;
    logic signed [31:0] write_mem_value;
  } tce_out_t;

  // register file write request
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } tce_reg_wr_t;

  // data memory write request
  typedef struct packed {
    logic                en;
    logic [MemAddrW-1:0] addr;
    logic [DataW-1:0]    data;
  } tce_mem_wr_t;

  // register index folded into the register file
  function automatic logic [RegIdxW-1:0] reg_idx(input logic [3:0] v);
    return RegIdxW'(v % RegCount);
  endfunction

  // memory address folded into the data memory
  function automatic logic [MemAddrW-1:0] mem_idx(input logic [7:0] v);
    return MemAddrW'(v % MemDepth);
  endfunction

  // fixed cycle cost of each operation
  function automatic logic [CostW-1:0] op_cost(input tce_op_e op);
    logic [CostW-1:0] c;
    unique case (op)
      OP_LOAD:  c = 5'd8;
      OP_STORE: c = 5'd8;
      OP_STI:   c = 5'd12;
      OP_IMM:   c = 5'd6;
      OP_ADD:   c = 5'd4;
      OP_SUB:   c = 5'd4;
      OP_JZ:    c = 5'd12;
      OP_MUL:   c = 5'd30;
      OP_MOVE:  c = 5'd2;
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/tce_ram.sv
// ----------------------------------------------------------------------------
// tce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/tce_regfile.sv
// ----------------------------------------------------------------------------
// tce_regfile
// Register file with two read ports, reset valid bits and forwarding of the
// most recent write over the registered read data.
// ----------------------------------------------------------------------------
module tce_regfile import tce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [RegIdxW-1:0] rd_a_addr_i,
  input  logic [RegIdxW-1:0] rd_b_addr_i,
  input  tce_reg_wr_t        wr_i,
  output logic [DataW-1:0]   rd_a_data_o,
  output logic [DataW-1:0]   rd_b_data_o
);

  logic [RegCount-1:0] vld_q;
  logic                vld_a_q, vld_b_q;
  logic [RegIdxW-1:0]  addr_a_q, addr_b_q;
  tce_reg_wr_t         last_q;
  logic [DataW-1:0]    ram_a, ram_b;

  // two copies written alike give two read ports
  tce_ram #(.WIDTH(DataW), .DEPTH(RegCount)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (wr_i.en),
    .waddr_i(wr_i.idx),
    .wdata_i(wr_i.data),
    .re_i   (rd_en_i),
    .raddr_i(rd_a_addr_i),
    .rdata_o(ram_a)
  );

  tce_ram #(.WIDTH(DataW), .DEPTH(RegCount)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (wr_i.en),
    .waddr_i(wr_i.idx),
    .wdata_i(wr_i.data),
    .re_i   (rd_en_i),
    .raddr_i(rd_b_addr_i),
    .rdata_o(ram_b)
  );

  // written-since-reset flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  // read address and flag captured with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      addr_a_q <= '0;
      addr_b_q <= '0;
    end else if (rd_en_i) begin
      vld_a_q  <= vld_q[rd_a_addr_i];
      vld_b_q  <= vld_q[rd_b_addr_i];
      addr_a_q <= rd_a_addr_i;
      addr_b_q <= rd_b_addr_i;
    end
  end

  // latest write, for a read that raced it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (wr_i.en) begin
      last_q <= wr_i;
    end
  end

  // forwarded or stored value, zero if never written
  always_comb begin
    if (last_q.en && (last_q.idx == addr_a_q)) begin
      rd_a_data_o = last_q.data;
    end else if (vld_a_q) begin
      rd_a_data_o = ram_a;
    end else begin
      rd_a_data_o = '0;
    end
    if (last_q.en && (last_q.idx == addr_b_q)) begin
      rd_b_data_o = last_q.data;
    end else if (vld_b_q) begin
      rd_b_data_o = ram_b;
    end else begin
      rd_b_data_o = '0;
    end
  end

endmodule

### rtl/tce_dmem.sv
// ----------------------------------------------------------------------------
// tce_dmem
// Data memory with reset valid bits and forwarding of the most recent store
// over the registered read data.
// ----------------------------------------------------------------------------
module tce_dmem import tce_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [MemAddrW-1:0] rd_addr_i,
  input  tce_mem_wr_t         wr_i,
  output logic [DataW-1:0]    rd_data_o
);

  logic [MemDepth-1:0] vld_q;
  logic                vld_rd_q;
  logic [MemAddrW-1:0] addr_q;
  tce_mem_wr_t         last_q;
  logic [DataW-1:0]    ram_data;

  tce_ram #(.WIDTH(DataW), .DEPTH(MemDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_i.en),
    .waddr_i(wr_i.addr),
    .wdata_i(wr_i.data),
    .re_i   (rd_en_i),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_data)
  );

  // written-since-reset flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // read address and flag captured with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_rd_q <= 1'b0;
      addr_q   <= '0;
    end else if (rd_en_i) begin
      vld_rd_q <= vld_q[rd_addr_i];
      addr_q   <= rd_addr_i;
    end
  end

  // latest store, for a read that raced it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (wr_i.en) begin
      last_q <= wr_i;
    end
  end

  // forwarded or stored word, zero if never written
  always_comb begin
    if (last_q.en && (last_q.addr == addr_q)) begin
      rd_data_o = last_q.data;
    end else if (vld_rd_q) begin
      rd_data_o = ram_data;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

### rtl/tce_alu.sv
// ----------------------------------------------------------------------------
// tce_alu
// Executes one instruction on its operand values and builds the result,
// including the next program counter and the write requests.
// ----------------------------------------------------------------------------
module tce_alu import tce_pkg::*; (
  input  tce_in_t          item_i,
  input  logic [PcW-1:0]   pc_i,
  input  logic [DataW-1:0] ra_i,
  input  logic [DataW-1:0] rb_i,
  input  logic [DataW-1:0] mem_i,
  output tce_out_t         res_o
);

  tce_op_e             op;
  logic [PcW-1:0]      pc1;
  logic                rw, mw, bad;
  logic [DataW-1:0]    rval, mval;
  logic [MemAddrW-1:0] maddr;

  assign op = tce_op_e'(item_i.kind);

  // operation decode and datapath
  always_comb begin
    pc1   = pc_i + PcW'(1);
    rw    = 1'b0;
    mw    = 1'b0;
    bad   = 1'b0;
    rval  = '0;
    mval  = '0;
    maddr = '0;
    unique case (op)
      OP_LOAD: begin
        rw   = 1'b1;
        rval = mem_i;
      end
      OP_STORE: begin
        mw    = 1'b1;
        maddr = mem_idx(item_i.operand[7:0]);
        mval  = ra_i;
      end
      OP_STI: begin
        mw    = 1'b1;
        maddr = mem_idx(ra_i[7:0]);
        mval  = rb_i;
      end
      OP_IMM: begin
        rw   = 1'b1;
        rval = {{(DataW-OpndW){item_i.operand[OpndW-1]}}, item_i.operand};
      end
      OP_ADD: begin
        rw   = 1'b1;
        rval = ra_i + rb_i;
      end
      OP_SUB: begin
        rw   = 1'b1;
        rval = ra_i - rb_i;
      end
      OP_JZ: begin
        if (ra_i == '0) begin
          pc1 = pc1 + $unsigned(item_i.operand);
        end
      end
      OP_MUL: begin
        rw   = 1'b1;
        rval = ra_i * rb_i;
      end
      OP_MOVE: begin
        rw   = 1'b1;
        rval = rb_i;
      end
      default: begin
        bad = 1'b1;
        pc1 = pc_i;
      end
    endcase
  end

  // result transaction, unused write fields held at zero
  always_comb begin
    res_o                   = '0;
    res_o.next_pc           = pc1;
    res_o.cycle_cost        = op_cost(op);
    res_o.invalid_op        = bad;
    res_o.reg_written       = rw;
    res_o.write_reg_index   = rw ? reg_idx(item_i.first_reg) : '0;
    res_o.write_reg_value   = $signed(rval);
    res_o.mem_written       = mw;
    res_o.write_mem_address = maddr;
    res_o.write_mem_value   = $signed(mval);
  end

endmodule

### rtl/tiny_cpu_execute_unit_top.sv
// ----------------------------------------------------------------------------
// tiny_cpu_execute_unit_top
// Execute unit of a tiny processor: one decoded instruction per transaction
// against a 16-entry register file, a 256-word data memory and a PC.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (tce_in_t)
//   out     | output    | out_valid_o/ out_stall_i| out_data_o (tce_out_t)
//
// from acceptance to result an instruction passes the operand reads from the
// register file and data memory rams, then execute into the result register;
// one instruction enters per cycle when the output keeps moving
// reset clears the register file and memory through valid bits, so the
// block accepts work in the first cycle after reset
// the last register and memory write is forwarded over the ram read data
// the input stalls only when the execute stage holds an instruction that
// cannot move into a full, stalled result register
// ----------------------------------------------------------------------------
module tiny_cpu_execute_unit_top import tce_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tce_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tce_out_t out_data_o
);

  logic               accept;
  logic               s1_adv;
  logic               s1_valid_q;
  tce_in_t            s1_item_q;
  logic               out_valid_q;
  tce_out_t           out_q;
  logic [PcW-1:0]     pc_q;
  tce_out_t           res;
  logic [RegIdxW-1:0] rd_a_addr, rd_b_addr;
  logic [MemAddrW-1:0] dm_addr;
  logic [DataW-1:0]   ra, rb, md;
  tce_reg_wr_t        rf_wr;
  tce_mem_wr_t        dm_wr;

  // handshake
  assign s1_adv      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // operand read addresses from the incoming instruction
  assign rd_a_addr = reg_idx(in_data_i.first_reg);
  assign rd_b_addr = (tce_op_e'(in_data_i.kind) == OP_STI) ?
                     reg_idx(in_data_i.operand[3:0]) : reg_idx(in_data_i.operand[7:4]);
  assign dm_addr   = mem_idx(in_data_i.operand[7:0]);

  // state updates commit as the instruction leaves execute
  always_comb begin
    rf_wr      = '0;
    rf_wr.en   = s1_adv && res.reg_written;
    rf_wr.idx  = res.write_reg_index;
    rf_wr.data = $unsigned(res.write_reg_value);
    dm_wr      = '0;
    dm_wr.en   = s1_adv && res.mem_written;
    dm_wr.addr = res.write_mem_address;
    dm_wr.data = $unsigned(res.write_mem_value);
  end

  tce_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_a_addr_i(rd_a_addr),
    .rd_b_addr_i(rd_b_addr),
    .wr_i       (rf_wr),
    .rd_a_data_o(ra),
    .rd_b_data_o(rb)
  );

  tce_dmem u_dmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(dm_addr),
    .wr_i     (dm_wr),
    .rd_data_o(md)
  );

  tce_alu u_alu (
    .item_i(s1_item_q),
    .pc_i  (pc_q),
    .ra_i  (ra),
    .rb_i  (rb),
    .mem_i (md),
    .res_o (res)
  );

  // execute stage input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // program counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_adv) begin
      pc_q <= res.next_pc;
    end
  end

  // assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.invalid_op |->
      !out_data_o.reg_written && !out_data_o.mem_written && (out_data_o.cycle_cost == '0))
    else $error("invalid opcode produced a write or a cost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.reg_written && out_data_o.mem_written))
    else $error("register and memory written by one instruction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted instruction missing from execute stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && res.invalid_op |=> pc_q == $past(pc_q))
    else $error("program counter moved on an invalid opcode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && (out_q.next_pc == pc_q))
    else $error("result pc and program counter disagree");

endmodule
